[hw/rtl/sed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

	localparam int unsigned MAX_WIDTH     = 256;
	localparam int unsigned MAX_HEIGHT    = 256;
	localparam int unsigned FRACTION_BITS = 5;
	localparam int unsigned COL_W         = $clog2(MAX_WIDTH);
	localparam int unsigned ADDR_W        = COL_W + 1;
	localparam int unsigned DEPTH         = 2 * MAX_WIDTH;
	localparam int unsigned EPOCH_W       = 8;
	localparam int unsigned ERR_W         = 16;
	localparam int unsigned SHARE_W       = 12;
	localparam int unsigned NUM_LANES     = 3;
	localparam int unsigned CFG_W         = 9;
	localparam int unsigned IDX_W         = 16;

	// Reciprocal of 9 scaled by 2**16, exact for dividends below 2**15.
	localparam logic [12:0] RECIP9 = 13'd7282;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	typedef enum logic [1:0] {
		WT_1,
		WT_2,
		WT_4,
		WT_6
	} weight_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_DIV,
		ST_ROW,
		ST_RD,
		ST_MUL,
		ST_SHR,
		ST_SPREAD
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic share_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]             tag;
		logic [NUM_LANES*ERR_W-1:0]     errs;
	} entry_t;

endpackage
`default_nettype wire

[hw/rtl/sed_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module sed_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [sed_pkg::IDX_W-1:0]       dividend,
	input  wire logic [sed_pkg::CFG_W-1:0]       divisor,
	output logic                                 done,
	output logic [sed_pkg::IDX_W-1:0]            quotient,
	output logic [sed_pkg::COL_W-1:0]            remainder
);

	localparam int unsigned CNT_W = $clog2(sed_pkg::IDX_W + 1);

	logic [sed_pkg::CFG_W-1:0] rem_q;
	logic [sed_pkg::IDX_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [sed_pkg::CFG_W:0]   trial;
	logic                      fits;

	assign trial = {rem_q, quo_q[sed_pkg::IDX_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(sed_pkg::IDX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? sed_pkg::CFG_W'(trial - {1'b0, divisor})
			              : trial[sed_pkg::CFG_W-1:0];
			quo_q <= {quo_q[sed_pkg::IDX_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[sed_pkg::COL_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/sed_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module sed_store (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [sed_pkg::ADDR_W-1:0]  waddr,
	input  wire sed_pkg::entry_t             wdata,
	input  wire logic [sed_pkg::ADDR_W-1:0]  raddr,
	output sed_pkg::entry_t                  rdata
);

	sed_pkg::entry_t mem [sed_pkg::DEPTH];
	sed_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/sed_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module sed_lane (
	input  wire logic                               clk,
	input  wire sed_pkg::lane_ctrl_t                ctrl,
	input  wire logic signed [sed_pkg::ERR_W-1:0]   err,
	input  wire logic [7:0]                         src,
	input  wire logic [7:0]                         chs,
	input  wire logic signed [sed_pkg::ERR_W-1:0]   acc,
	input  wire sed_pkg::weight_t                   wsel,
	output logic signed [sed_pkg::SHARE_W-1:0]      share,
	output logic signed [sed_pkg::ERR_W-1:0]        acc_next
);

	localparam int unsigned SUM_W = sed_pkg::ERR_W + 1;

	logic signed [8:0]                   diff;
	logic signed [SUM_W-1:0]             sum;
	logic [SUM_W-1:0]                    mag;
	logic [sed_pkg::ERR_W-1:0]           biased;
	logic [27:0]                         prod_s1;
	logic                                neg_s1;
	logic [sed_pkg::SHARE_W-1:0]         quo;
	logic signed [sed_pkg::SHARE_W-1:0]  share_q;
	logic signed [14:0]                  wt;
	logic signed [SUM_W-1:0]             acc_sum;

	always_comb begin
		diff   = $signed({1'b0, src}) - $signed({1'b0, chs});
		sum    = SUM_W'(err) + SUM_W'($signed({diff, {sed_pkg::FRACTION_BITS{1'b0}}}));
		mag    = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
		biased = sed_pkg::ERR_W'(mag + SUM_W'(9));
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= 28'(biased[sed_pkg::ERR_W-1:1] * sed_pkg::RECIP9);
			neg_s1  <= sum[SUM_W-1];
		end
		if (ctrl.share_en) begin
			share_q <= share;
		end
	end

	always_comb begin
		quo = prod_s1[27:16];
		if (!neg_s1) begin
			share = (quo > 12'd2047) ? 12'sd2047 : $signed(quo);
		end else begin
			share = (quo > 12'd2048) ? -12'sd2048 : $signed(-quo);
		end
	end

	always_comb begin
		case (wsel)
			sed_pkg::WT_1: wt = 15'(share_q);
			sed_pkg::WT_2: wt = 15'(share_q) <<< 1;
			sed_pkg::WT_4: wt = 15'(share_q) <<< 2;
			default:       wt = (15'(share_q) <<< 2) + (15'(share_q) <<< 1);
		endcase
		acc_sum = SUM_W'(acc) + SUM_W'(wt);
		if (acc_sum > 17'sd32767) begin
			acc_next = 16'sh7FFF;
		end else if (acc_sum < -17'sd32768) begin
			acc_next = -16'sh8000;
		end else begin
			acc_next = acc_sum[sed_pkg::ERR_W-1:0];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/serpentine_error_diffusion.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Beat contents
// s_axis   in         tdata: pixel index, source R/G/B, chosen R/G/B
// m_axis   out        tdata: red, green and blue share, signed Q6.5
// cfg      in         one register write per cycle with cfg_we high
//
// A pixel inside the frame passes these steps in order: take the beat, run the index
// divider from its start to its done strobe, update the row state, read the own error
// and form the shares, then spread them pipelined through the store's one write and
// one read port. An off-frame pixel skips the spread. Disabled items are dropped.
// After reset a pass clearing all 512 entries runs before the first beat is taken;
// every 256th clearing of a row slot costs another such pass.
// The result register lets the next pixel start while a share waits on m_axis.
module serpentine_error_diffusion (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pixel_index, source_red, source_green, source_blue,
	// chosen_red, chosen_green, chosen_blue
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// share_red, share_green, share_blue, four zero bits
	output logic [39:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int unsigned CW = sed_pkg::COL_W;
	localparam int unsigned AW = sed_pkg::ADDR_W;
	localparam int unsigned EW = sed_pkg::ERR_W;
	localparam int unsigned SW = sed_pkg::SHARE_W;
	localparam int unsigned NL = sed_pkg::NUM_LANES;

	sed_pkg::state_t state_q, state_d;

	logic [8:0]  width_q, height_q;
	logic        enable_q;
	logic [8:0]  w_eff, h_eff;

	logic [sed_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                src_q [NL];
	logic [7:0]                chs_q [NL];

	logic                      div_start, div_done;
	logic [sed_pkg::IDX_W-1:0] row_div;
	logic [CW-1:0]             col_div;
	logic [sed_pkg::IDX_W-1:0] row_q;
	logic [CW-1:0]             col_q;
	logic [7:0]                cur_row_q;
	logic                      in_frame, slot, nslot, has_next;
	logic                      row_begin, wrap_n, wrap_s, row_wrap;
	logic [1:0]                wrap_mask;

	logic [sed_pkg::EPOCH_W-1:0] ep_q [2];
	logic [1:0]                  sweep_mask_q;
	logic [AW-1:0]               sweep_q;
	logic                        resume_q;

	logic [2:0]  step_q;
	logic        spr_v_s1;
	logic [AW-1:0] wr_addr_s1;
	sed_pkg::weight_t wt_s1;
	logic [AW-1:0] rd_addr_s1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	sed_pkg::entry_t mem_wdata, mem_rdata;
	logic          rd_hit;

	logic          tgt_en;
	logic [AW-1:0] tgt_addr;
	sed_pkg::weight_t tgt_wt;
	logic [8:0]    col9;

	sed_pkg::lane_ctrl_t lane_ctrl;
	logic signed [SW-1:0] share [NL];
	logic signed [EW-1:0] acc_next [NL];
	logic signed [EW-1:0] err_in [NL];
	logic signed [EW-1:0] acc_in [NL];

	logic          out_v_q;
	logic [39:0]   out_q;
	logic          out_load;

	always_comb begin
		w_eff = (width_q < 9'd3) ? 9'd3 :
		        (width_q > 9'(sed_pkg::MAX_WIDTH)) ? 9'(sed_pkg::MAX_WIDTH) : width_q;
		h_eff = (height_q < 9'd1) ? 9'd1 :
		        (height_q > 9'(sed_pkg::MAX_HEIGHT)) ? 9'(sed_pkg::MAX_HEIGHT) : height_q;
		slot  = row_q[0];
		nslot = ~row_q[0];
		in_frame = row_q < sed_pkg::IDX_W'(h_eff);
		has_next = (17'(row_q) + 17'd1) < 17'(h_eff);
		col9  = {1'b0, col_q};
		row_begin = in_frame && (col_q == '0 || row_q != sed_pkg::IDX_W'(cur_row_q));
		wrap_n    = row_begin && (ep_q[nslot] == '1);
		wrap_s    = row_begin && (row_q == '0) && (ep_q[slot] == '1);
		row_wrap  = wrap_n || wrap_s;
		wrap_mask = slot ? {wrap_s, wrap_n} : {wrap_n, wrap_s};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd80;
			height_q <= 9'd25;
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sed_pkg::REG_WIDTH:  width_q  <= cfg_data;
				sed_pkg::REG_HEIGHT: height_q <= cfg_data;
				sed_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sed_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (idx_q),
		.divisor   (w_eff),
		.done      (div_done),
		.quotient  (row_div),
		.remainder (col_div)
	);

	always_comb begin
		tgt_en   = 1'b0;
		tgt_addr = {slot, col_q};
		tgt_wt   = sed_pkg::WT_1;
		case (step_q)
			3'd0: begin
				tgt_wt = sed_pkg::WT_4;
				if (slot) begin
					tgt_en   = col_q >= CW'(1);
					tgt_addr = {slot, CW'(col9 - 9'd1)};
				end else begin
					tgt_en   = col9 != w_eff - 9'd1;
					tgt_addr = {slot, CW'(col9 + 9'd1)};
				end
			end
			3'd1: begin
				tgt_wt = sed_pkg::WT_2;
				if (slot) begin
					tgt_en   = col_q >= CW'(2);
					tgt_addr = {slot, CW'(col9 - 9'd2)};
				end else begin
					tgt_en   = col9 < w_eff - 9'd2;
					tgt_addr = {slot, CW'(col9 + 9'd2)};
				end
			end
			3'd2: begin
				tgt_en   = has_next && col_q >= CW'(2);
				tgt_addr = {nslot, CW'(col9 - 9'd2)};
			end
			3'd3: begin
				tgt_wt   = sed_pkg::WT_2;
				tgt_en   = has_next && col_q >= CW'(1);
				tgt_addr = {nslot, CW'(col9 - 9'd1)};
			end
			3'd4: begin
				tgt_wt   = sed_pkg::WT_6;
				tgt_en   = has_next;
				tgt_addr = {nslot, col_q};
			end
			3'd5: begin
				tgt_wt   = sed_pkg::WT_2;
				tgt_en   = has_next && col9 != w_eff - 9'd1;
				tgt_addr = {nslot, CW'(col9 + 9'd1)};
			end
			3'd6: begin
				tgt_en   = has_next && col9 < w_eff - 9'd2;
				tgt_addr = {nslot, CW'(col9 + 9'd2)};
			end
			default: ;
		endcase
	end

	assign mem_raddr = (state_q == sed_pkg::ST_SPREAD) ? tgt_addr : {slot, col_q};
	assign rd_hit    = mem_rdata.tag == ep_q[rd_addr_s1[AW-1]];

	always_comb begin
		if (state_q == sed_pkg::ST_SWEEP) begin
			mem_we    = sweep_mask_q[sweep_q[AW-1]];
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else begin
			mem_we    = spr_v_s1;
			mem_waddr = wr_addr_s1;
			mem_wdata.tag = ep_q[wr_addr_s1[AW-1]];
			for (int k = 0; k < NL; k++) begin
				mem_wdata.errs[k*EW +: EW] = acc_next[k];
			end
		end
	end

	sed_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign lane_ctrl.mul_en   = state_q == sed_pkg::ST_MUL;
	assign lane_ctrl.share_en = state_q == sed_pkg::ST_SHR;

	for (genvar g = 0; g < NL; g++) begin : g_lane
		always_comb begin
			acc_in[g] = rd_hit ? $signed(mem_rdata.errs[g*EW +: EW]) : '0;
			err_in[g] = in_frame ? acc_in[g] : '0;
		end
		sed_lane u_lane (
			.clk      (clk),
			.ctrl     (lane_ctrl),
			.err      (err_in[g]),
			.src      (src_q[g]),
			.chs      (chs_q[g]),
			.acc      (acc_in[g]),
			.wsel     (wt_s1),
			.share    (share[g]),
			.acc_next (acc_next[g])
		);
	end

	assign out_load = (state_q == sed_pkg::ST_SHR) && (!out_v_q || m_axis_tready);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			sed_pkg::ST_SWEEP: begin
				if (sweep_q == AW'(sed_pkg::DEPTH - 1)) begin
					state_d = resume_q ? sed_pkg::ST_RD : sed_pkg::ST_IDLE;
				end
			end
			sed_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && enable_q) begin
					state_d = sed_pkg::ST_DIV;
				end
			end
			sed_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sed_pkg::ST_ROW;
				end
			end
			sed_pkg::ST_ROW: begin
				state_d = row_wrap ? sed_pkg::ST_SWEEP : sed_pkg::ST_RD;
			end
			sed_pkg::ST_RD: begin
				state_d = sed_pkg::ST_MUL;
			end
			sed_pkg::ST_MUL: begin
				state_d = sed_pkg::ST_SHR;
			end
			sed_pkg::ST_SHR: begin
				if (out_load) begin
					state_d = in_frame ? sed_pkg::ST_SPREAD : sed_pkg::ST_IDLE;
				end
			end
			sed_pkg::ST_SPREAD: begin
				if (step_q == 3'd7) begin
					state_d = sed_pkg::ST_IDLE;
				end
			end
			default: state_d = sed_pkg::ST_IDLE;
		endcase
	end

	logic div_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sed_pkg::ST_SWEEP;
			sweep_q      <= '0;
			sweep_mask_q <= 2'b11;
			resume_q     <= 1'b0;
			ep_q[0]      <= '0;
			ep_q[1]      <= '0;
			cur_row_q    <= '0;
			step_q       <= '0;
			spr_v_s1     <= 1'b0;
			out_v_q      <= 1'b0;
			div_go_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			div_go_q <= (state_q == sed_pkg::ST_IDLE) && s_axis_tvalid && enable_q;
			spr_v_s1 <= (state_q == sed_pkg::ST_SPREAD) && (step_q != 3'd7) && tgt_en;
			if (state_q == sed_pkg::ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == sed_pkg::ST_ROW) begin
				resume_q     <= row_wrap;
				sweep_q      <= '0;
				sweep_mask_q <= wrap_mask;
				if (row_begin) begin
					cur_row_q   <= row_q[7:0];
					ep_q[nslot] <= ep_q[nslot] + 1'b1;
					if (row_q == '0) begin
						ep_q[slot] <= ep_q[slot] + 1'b1;
					end
				end
			end
			if (state_q == sed_pkg::ST_SPREAD) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign div_start = div_go_q;

	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_raddr;
		wr_addr_s1 <= tgt_addr;
		wt_s1      <= tgt_wt;
		if (s_axis_tready && s_axis_tvalid) begin
			idx_q    <= s_axis_tdata[15:0];
			src_q[0] <= s_axis_tdata[23:16];
			src_q[1] <= s_axis_tdata[31:24];
			src_q[2] <= s_axis_tdata[39:32];
			chs_q[0] <= s_axis_tdata[47:40];
			chs_q[1] <= s_axis_tdata[55:48];
			chs_q[2] <= s_axis_tdata[63:56];
		end
		if (div_done) begin
			row_q <= row_div;
			col_q <= col_div;
		end
		if (out_load) begin
			out_q <= {4'b0, share[2], share[1], share[0]};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
	} share_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	serpentine_error_diffusion uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state.
	int err_store[3][sed_pkg::DEPTH];
	int unsigned row_now;
	int unsigned width_reg;
	int unsigned height_reg;
	bit enable_reg;

	share_t share_queue[$];
	int mismatches;
	int shares_seen;
	int pixels_sent;
	int idle_cycles;
	bit timed_out;
	bit sink_hold;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int round_div18(input int s);
		if (s >= 0) return (s + 9) / 18;
		return -((9 - s) / 18);
	endfunction

	function automatic void clear_row_slot(input int unsigned slot);
		for (int k = 0; k < 3; k++)
			for (int c = 0; c < sed_pkg::MAX_WIDTH; c++)
				err_store[k][slot * sed_pkg::MAX_WIDTH + c] = 0;
	endfunction

	function automatic void push_error(input int unsigned slot, input int unsigned col,
			input int shr[3], input int wgt);
		if (col >= sed_pkg::MAX_WIDTH) return;
		for (int k = 0; k < 3; k++)
			err_store[k][slot * sed_pkg::MAX_WIDTH + col] =
				sat(err_store[k][slot * sed_pkg::MAX_WIDTH + col] + shr[k] * wgt,
					-32768, 32767);
	endfunction

	function automatic void predict_pixel(input logic [63:0] beat);
		int unsigned w, h, p, row, col, slot, nslot;
		int shr[3];
		int e, s, c;
		bit in_frame;
		share_t r;
		if (!enable_reg) return;
		w = sat(width_reg, 3, sed_pkg::MAX_WIDTH);
		h = sat(height_reg, 1, sed_pkg::MAX_HEIGHT);
		p = beat[15:0];
		row = p / w;
		col = p % w;
		in_frame = row < h;
		slot = row & 1;
		nslot = slot ^ 1;
		if (in_frame && (col == 0 || row != row_now)) begin
			clear_row_slot(nslot);
			if (row == 0) clear_row_slot(slot);
			row_now = row;
		end
		for (int k = 0; k < 3; k++) begin
			s = beat[16 + 8 * k +: 8];
			c = beat[40 + 8 * k +: 8];
			e = in_frame ? err_store[k][slot * sed_pkg::MAX_WIDTH + col] : 0;
			shr[k] = sat(round_div18(e + (s - c) * (1 << sed_pkg::FRACTION_BITS)),
				-2048, 2047);
		end
		r.red = shr[0][11:0];
		r.green = shr[1][11:0];
		r.blue = shr[2][11:0];
		share_queue.push_back(r);
		if (!in_frame) return;
		if (slot) begin
			if (col >= 1) push_error(slot, col - 1, shr, 4);
			if (col >= 2) push_error(slot, col - 2, shr, 2);
		end else begin
			if (col != w - 1) push_error(slot, col + 1, shr, 4);
			if (col + 2 < w) push_error(slot, col + 2, shr, 2);
		end
		if (row + 1 < h) begin
			if (col >= 2) push_error(nslot, col - 2, shr, 1);
			if (col >= 1) push_error(nslot, col - 1, shr, 2);
			push_error(nslot, col, shr, 6);
			if (col != w - 1) push_error(nslot, col + 1, shr, 2);
			if (col + 2 < w) push_error(nslot, col + 2, shr, 1);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [11:0] got,
			input logic [11:0] want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
	endtask

	// Sink side: random backpressure and checking of each share beat.
	initial begin
		share_t want;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				shares_seen++;
				if (share_queue.size() == 0) begin
					report_mismatch("share beat with nothing expected", m_axis_tdata[11:0],
						12'd0);
				end else begin
					want = share_queue.pop_front();
					if (m_axis_tdata[11:0] !== want.red)
						report_mismatch("red", m_axis_tdata[11:0], want.red);
					if (m_axis_tdata[23:12] !== want.green)
						report_mismatch("green", m_axis_tdata[23:12], want.green);
					if (m_axis_tdata[35:24] !== want.blue)
						report_mismatch("blue", m_axis_tdata[35:24], want.blue);
				end
			end
			m_axis_tready <= !sink_hold && (no_idle || $urandom_range(99) >= 14);
		end
	end

	// Watchdog on cycles without any accepted beat.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send_pixel(input int unsigned idx, input logic [7:0] sr, input logic [7:0] sg,
			input logic [7:0] sb, input logic [7:0] cr, input logic [7:0] cg,
			input logic [7:0] cb);
		logic [63:0] beat;
		beat = {cb, cg, cr, sb, sg, sr, idx[15:0]};
		if (!no_idle && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (!no_idle && $urandom_range(99) < 14);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		do @(posedge clk); while (!s_axis_tready);
		predict_pixel(beat);
		pixels_sent++;
	endtask

	task automatic send_random_pixel(input int unsigned idx);
		send_pixel(idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (share_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sed_pkg::REG_WIDTH) width_reg = val;
		else if (idx == sed_pkg::REG_HEIGHT) height_reg = val;
		else if (idx == sed_pkg::REG_ENABLE) enable_reg = val[0];
		@(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		drain();
		write_reg(sed_pkg::REG_WIDTH, 9'(w));
		write_reg(sed_pkg::REG_HEIGHT, 9'(h));
	endtask

	task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned n);
		int unsigned ew, eh, p;
		ew = sat(w, 3, sed_pkg::MAX_WIDTH);
		eh = sat(h, 1, sed_pkg::MAX_HEIGHT);
		p = 0;
		for (int i = 0; i < n; i++) begin
			send_random_pixel(p);
			p++;
			if (p >= ew * eh) p = 0;
		end
	endtask

	task automatic test_extremes();
		set_frame(3, 3);
		send_pixel(0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_pixel(1, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(2, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'hFF, 8'h55);
		for (int i = 3; i < 9; i++) send_pixel(i, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
		send_pixel(9, 8'h80, 8'h7F, 8'h01, 8'h7F, 8'h80, 8'hFE);
		send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_pixel(4, 8'h12, 8'h34, 8'h56, 8'h65, 8'h43, 8'h21);
		send_pixel(0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06);
	endtask

	task automatic test_size_clamps();
		set_frame(0, 0);
		run_frame(0, 0, 8);
		set_frame(9'h1FF, 9'h1FF);
		for (int i = 0; i < 6; i++) send_random_pixel($urandom_range(65535));
		send_random_pixel(65535);
	endtask

	task automatic test_disabled();
		drain();
		write_reg(sed_pkg::REG_ENABLE, 9'd0);
		for (int i = 0; i < 10; i++) send_random_pixel($urandom_range(65535));
		drain();
		write_reg(sed_pkg::REG_ENABLE, 9'd1);
	endtask

	task automatic test_backpressure();
		set_frame(5, 4);
		sink_hold = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				sink_hold = 1'b0;
			end
			run_frame(5, 4, 12);
		join
		drain();
		run_frame(5, 4, 20);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, n;
		for (int f = 0; f < 30; f++) begin
			case ($urandom_range(4))
				0: begin w = 3; h = $urandom_range(1, 6); end
				1: begin w = 256; h = $urandom_range(1, 3); end
				2: begin w = $urandom_range(3, 12); h = 1; end
				default: begin w = $urandom_range(3, 20); h = $urandom_range(2, 8); end
			endcase
			set_frame(w, h);
			no_idle = (f == 10);
			n = $urandom_range(30, 70);
			run_frame(w, h, n);
			// Some stray pixels, including ones past the last row.
			for (int i = 0; i < 3; i++) send_random_pixel($urandom_range(65535));
			no_idle = 1'b0;
		end
		set_frame(80, 25);
		for (int i = 0; i < 40; i++) send_random_pixel($urandom_range(65535));
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		width_reg = 80;
		height_reg = 25;
		enable_reg = 1'b1;
		row_now = 0;
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < sed_pkg::DEPTH; i++) err_store[k][i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_size_clamps();
		test_disabled();
		test_backpressure();
		test_random_frames();
		drain();
		$display("Sent %0d pixels and checked %0d share beats across frame sizes,", pixels_sent,
			shares_seen);
		$display("size clamps, off-frame pixels, disabled mode and backpressure.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
